[design/utf8d_pkg.sv]
// shared types and constants of the utf-8 validating decoder
package utf8d_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 3;
	localparam int unsigned AccW   = 31;
	localparam int unsigned CpW    = 21;

	localparam logic [AccW-1:0] MinLen1   = AccW'(32'h0000_0080);
	localparam logic [AccW-1:0] MinLen2   = AccW'(32'h0000_0800);
	localparam logic [AccW-1:0] MinLen3   = AccW'(32'h0001_0000);
	localparam logic [AccW-1:0] MinLen4   = AccW'(32'h0020_0000);
	localparam logic [AccW-1:0] MinLen5   = AccW'(32'h0400_0000);
	localparam logic [AccW-1:0] LineSep   = AccW'(32'h0000_2028);
	localparam logic [AccW-1:0] ParaSep   = AccW'(32'h0000_2029);
	localparam logic [AccW-1:0] C1End     = AccW'(32'h0000_00A0);
	localparam logic [AccW-1:0] SurLo     = AccW'(32'h0000_D800);
	localparam logic [AccW-1:0] SurEnd    = AccW'(32'h0000_E000);
	localparam logic [AccW-1:0] MaxCp     = AccW'(32'h0010_FFFF);
	localparam logic [AccW-1:0] TagLo     = AccW'(32'h000E_0000);
	localparam logic [AccW-1:0] TagHi     = AccW'(32'h000E_007F);
	localparam logic [AccW-1:0] Bom       = AccW'(32'h0000_FEFF);
	localparam logic [AccW-1:0] NonCharA  = AccW'(32'h0000_FFFE);
	localparam logic [AccW-1:0] NonCharB  = AccW'(32'h0000_FFFF);
	localparam logic [CpW-1:0]  NelCp     = CpW'(32'h0000_0085);
	localparam logic [CpW-1:0]  ReplCp    = CpW'(32'h0000_FFFD);

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_NONE    = 2'd1,
		ST_INVALID = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	typedef struct packed {
		logic [CountW-1:0] bytes_left;
		logic [CountW-1:0] seq_length;
		logic [AccW-1:0]   accum_value;
	} dec_state_t;

	typedef struct packed {
		status_t          status;
		logic [CpW-1:0]   code_point;
	} dec_result_t;

endpackage

[design/utf8d_check.sv]
// final checks on a completed sequence value
module utf8d_check
	import utf8d_pkg::*;
(
	input  logic [AccW-1:0]   value,
	input  logic [CountW-1:0] seq_length,
	output dec_result_t       result
);

	logic overlong;

	always_comb begin
		overlong = (value < MinLen1)
			|| (value < MinLen2 && seq_length >= CountW'(2))
			|| (value < MinLen3 && seq_length >= CountW'(3))
			|| (value < MinLen4 && seq_length >= CountW'(4))
			|| (value < MinLen5 && seq_length >= CountW'(5));
	end

	always_comb begin
		result.status     = ST_VALID;
		result.code_point = '0;
		priority if (overlong) begin
			result.status = ST_INVALID;
		end else if (value == LineSep || value == ParaSep) begin
			result.code_point = NelCp;
		end else if (value < C1End) begin
			result.code_point = ReplCp;
		end else if (value >= SurLo && value < SurEnd) begin
			result.status = ST_INVALID;
		end else if (value > MaxCp) begin
			result.status = ST_INVALID;
		end else if (value >= TagLo && value <= TagHi) begin
			result.status = ST_NONE;
		end else if (value == Bom) begin
			result.status = ST_NONE;
		end else if (value == NonCharA || value == NonCharB) begin
			result.status = ST_INVALID;
		end else begin
			result.code_point = value[CpW-1:0];
		end
	end

endmodule

[design/utf8d_step.sv]
// per-byte decode: next sequence state and the result of one item
module utf8d_step
	import utf8d_pkg::*;
(
	input  logic [ByteW-1:0] in_byte,
	input  dec_state_t       cur,
	output dec_state_t       nxt,
	output dec_result_t      result
);

	logic [AccW-1:0]   acc_shift;
	logic [CountW-1:0] left_dec;
	dec_result_t       fin;

	assign acc_shift = {cur.accum_value[AccW-7:0], in_byte[5:0]};
	assign left_dec  = cur.bytes_left - CountW'(1);

	utf8d_check u_check (
		.value      (acc_shift),
		.seq_length (cur.seq_length),
		.result     (fin)
	);

	always_comb begin
		nxt               = cur;
		result.status     = ST_NONE;
		result.code_point = '0;
		if (cur.bytes_left == '0) begin
			priority if (in_byte[7] == 1'b0) begin
				result.status     = ST_VALID;
				result.code_point = CpW'(in_byte);
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.bytes_left  = CountW'(1);
				nxt.seq_length  = CountW'(1);
				nxt.accum_value = AccW'(in_byte[4:0]);
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.bytes_left  = CountW'(2);
				nxt.seq_length  = CountW'(2);
				nxt.accum_value = AccW'(in_byte[3:0]);
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.bytes_left  = CountW'(3);
				nxt.seq_length  = CountW'(3);
				nxt.accum_value = AccW'(in_byte[2:0]);
			end else if (in_byte[7:2] == 6'b111110) begin
				nxt.bytes_left  = CountW'(4);
				nxt.seq_length  = CountW'(4);
				nxt.accum_value = AccW'(in_byte[1:0]);
			end else if (in_byte[7:1] == 7'b1111110) begin
				nxt.bytes_left  = CountW'(5);
				nxt.seq_length  = CountW'(5);
				nxt.accum_value = AccW'(in_byte[0]);
			end else begin
				result.status = ST_INVALID;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			// byte not consumed, source presents it again
			nxt.bytes_left = '0;
			result.status  = ST_TRUNC;
		end else begin
			nxt.accum_value = acc_shift;
			nxt.bytes_left  = left_dec;
			if (left_dec == '0) begin
				result = fin;
			end
		end
	end

endmodule

[design/utf8_validating_decoder.sv]
// top level of the utf-8 validating decoder: input register, decode, result register
//
// Byte channel: byte_valid, byte_stall, in_byte. A byte is taken at a rising
// edge with byte_valid high and byte_stall low.
// Result channel: res_valid, res_stall, status, code_point. Every byte gives
// exactly one result item, in order.
// A taken byte waits in the input register, and its result then waits in the
// result register until it is taken.
// Throughput: one byte per cycle while res_stall does not hold a result; the
// sequence state is updated by the decode logic between the two registers in
// the same cycle, so consecutive bytes need no gap.
// When res_stall is high with a result waiting, the result holds, the byte in
// the input register waits and byte_stall rises, so at most two items are
// held inside. A status of truncated means the byte was not consumed and must
// be sent again.
// Reset clears both valid flags and the sequence state (idle, empty value).
module utf8_validating_decoder
	import utf8d_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [ByteW-1:0]     in_byte,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           status,
	output logic [CpW-1:0]       code_point
);

	logic        valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic        valid_s2;
	dec_result_t result_s2;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t result_nxt;
	logic        s2_free;
	logic        s1_move;
	logic        take;

	assign s2_free    = !valid_s2 || !res_stall;
	assign s1_move    = valid_s1 && s2_free;
	assign byte_stall = valid_s1 && !s2_free;
	assign take       = byte_valid && !byte_stall;

	utf8d_step u_step (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.result  (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s1_move) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
		end
		if (s1_move) begin
			result_s2 <= result_nxt;
		end
	end

	assign res_valid  = valid_s2;
	assign status     = result_s2.status;
	assign code_point = result_s2.code_point;

endmodule
